// ===== rtl/grm_pkg.sv =====
// shared types and constants of the grid ray march block
// used by the top level, the direction unit, the axis trackers and the checker
package grm_pkg;

	// stream widths
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;

	// field widths
	localparam int ORIGIN_W = 17;
	localparam int ANGLE_W  = 12;
	localparam int DIST_W   = 10;
	localparam int WALL_W   = 25;
	localparam int CELL_SZ_W = 8;
	localparam int LIMIT_W  = 10;
	localparam int CFG_ADDR_W = 2;

	// internal widths
	localparam int POS_W   = ORIGIN_W + 8;   // origin in q16
	localparam int SPAN_W  = CELL_SZ_W + 16; // cell edge in q16
	localparam int REM_W   = SPAN_W + 2;     // signed remainder inside a cell
	localparam int DIR_W   = 18;             // q16 unit vector component
	localparam int CORD_W  = 32;             // q30 rotator datapath
	localparam int ITER_W  = 4;
	localparam int STEP_W  = DIST_W + 1;     // step count up to limit plus one
	localparam int IDX_W   = 7;              // wall bit index, grid up to 11 by 11

	localparam logic [ITER_W-1:0] ITER_LAST = 4'd15;
	localparam logic signed [CORD_W-1:0] CORD_X0 = 32'sd652032875;

	// register reset values
	localparam logic [WALL_W-1:0]    WALL_MAP_RST     = 25'd24700296;
	localparam logic [CELL_SZ_W-1:0] CELL_SIZE_RST    = 8'd50;
	localparam logic [LIMIT_W-1:0]   RENDER_LIMIT_RST = 10'd250;

	// register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WALL_MAP     = 2'd0,
		REG_CELL_SIZE    = 2'd1,
		REG_RENDER_LIMIT = 2'd2
	} cfg_reg_t;

	// axis tracker status
	typedef struct packed {
		logic busy;
		logic in_grid;
	} axis_stat_t;

	// arctangent of 2^-i in 1/2^32 turn
	function automatic logic signed [CORD_W-1:0] arc_of(input logic [ITER_W-1:0] i);
		logic signed [CORD_W-1:0] a;
		case (i)
			4'd0:  a = 32'sd536870912;
			4'd1:  a = 32'sd316933406;
			4'd2:  a = 32'sd167458907;
			4'd3:  a = 32'sd85004756;
			4'd4:  a = 32'sd42667331;
			4'd5:  a = 32'sd21354465;
			4'd6:  a = 32'sd10679838;
			4'd7:  a = 32'sd5340245;
			4'd8:  a = 32'sd2670163;
			4'd9:  a = 32'sd1335087;
			4'd10: a = 32'sd667544;
			4'd11: a = 32'sd333772;
			4'd12: a = 32'sd166886;
			4'd13: a = 32'sd83443;
			4'd14: a = 32'sd41722;
			4'd15: a = 32'sd20861;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/grid_ray_march_distance.sv =====
// top level of the grid ray march block: configuration registers, sequencer, output register
// depends on grm_pkg, grm_cordic and grm_axis
//
// A ray item enters with its origin (q8) and a 12-bit binary angle; one result item leaves
// with a hit flag and the step count to the first wall cell, or a miss with distance zero.
// The block takes one ray at a time and is not ready while a ray is in flight. The direction
// comes from a 16-pass iterative rotator plus a rounding step; the start cell search runs
// beside it. The march then examines one position per cycle, so a ray that runs to the end
// examines render_limit + 1 positions and then gives up, and the done state moves the result
// into the output register once that is free or being emptied. A new ray is taken while
// the previous result still waits in the output register.
module grid_ray_march_distance import grm_pkg::*; #(
	parameter int MAP_COLS = 5,
	parameter int MAP_ROWS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// ray items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,   // origin_x[16:0], origin_y[33:17], ray_angle[45:34], zero pad
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,   // hit[0], distance[10:1], zero pad
	// register writes
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [WALL_W-1:0]      cfg_wdata
);

	localparam int CX_W = $clog2(MAP_COLS + 1);
	localparam int CY_W = $clog2(MAP_ROWS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIR   = 4'b0010,
		ST_MARCH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [WALL_W-1:0]    wall_map_q;
	logic [CELL_SZ_W-1:0] cell_size_q;
	logic [LIMIT_W-1:0]   render_limit_q;

	// ray in flight
	logic [STEP_W-1:0]    n_q;
	logic                 res_hit_q;
	logic [DIST_W-1:0]    res_dist_q;

	// output register
	logic                 m_tvalid_q;
	logic                 m_hit_q;
	logic [DIST_W-1:0]    m_dist_q;

	logic                 accept, dir_valid, step_en, over_limit, outside, wall;
	logic signed [DIR_W-1:0] dx, dy;
	logic [SPAN_W-1:0]    span;
	logic [CELL_SZ_W-1:0] cs_eff;
	axis_stat_t           stat_x, stat_y;
	logic [CX_W-1:0]      cell_x;
	logic [CY_W-1:0]      cell_y;
	logic [IDX_W-1:0]     idx;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// a zero cell size acts as one
	assign cs_eff = (cell_size_q == '0) ? CELL_SZ_W'(1) : cell_size_q;
	assign span   = {cs_eff, 16'b0};

	grm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.angle  (s_tdata[2*ORIGIN_W +: ANGLE_W]),
		.valid  (dir_valid),
		.dx     (dx),
		.dy     (dy)
	);

	grm_axis #(.COUNT(MAP_COLS)) u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.pos     ($signed({s_tdata[0 +: ORIGIN_W], 8'b0})),
		.step    (step_en),
		.d       (dx),
		.span    (span),
		.stat    (stat_x),
		.cell_no (cell_x)
	);

	grm_axis #(.COUNT(MAP_ROWS)) u_axis_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.pos     ($signed({s_tdata[ORIGIN_W +: ORIGIN_W], 8'b0})),
		.step    (step_en),
		.d       (dy),
		.span    (span),
		.stat    (stat_y),
		.cell_no (cell_y)
	);

	// per-step decision: limit first, then grid bounds, then wall
	always_comb begin
		over_limit = n_q > {1'b0, render_limit_q};
		outside    = !stat_x.in_grid || !stat_y.in_grid;
		idx        = IDX_W'(cell_y) * IDX_W'(MAP_COLS) + IDX_W'(cell_x);
		// bits past the wall map are never walls
		wall       = (idx < IDX_W'(WALL_W)) && wall_map_q[idx[4:0]];
		step_en    = (state_q == ST_MARCH) && !over_limit && !outside && !wall;
	end

	// register writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_map_q     <= WALL_MAP_RST;
			cell_size_q    <= CELL_SIZE_RST;
			render_limit_q <= RENDER_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WALL_MAP:     wall_map_q     <= cfg_wdata;
				REG_CELL_SIZE:    cell_size_q    <= cfg_wdata[CELL_SZ_W-1:0];
				REG_RENDER_LIMIT: render_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// output register filled from the done state, emptied when taken
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					// start cell search is shorter than the rotator, both must be done
					if (dir_valid && !stat_x.busy && !stat_y.busy) begin
						state_q <= ST_MARCH;
					end
				end
				ST_MARCH: begin
					if (over_limit || outside || wall) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// step count and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DIR) begin
			n_q <= '0;
		end else if (step_en) begin
			n_q <= n_q + STEP_W'(1);
		end
		if (state_q == ST_MARCH) begin
			res_hit_q  <= !over_limit && !outside && wall;
			res_dist_q <= (!over_limit && !outside && wall) ? n_q[DIST_W-1:0] : '0;
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_hit_q  <= res_hit_q;
			m_dist_q <= res_dist_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - DIST_W - 1)'(0), m_dist_q, m_hit_q};

endmodule

// ===== rtl/grm_cordic.sv =====
// iterative rotator: one shared add/shift stage, sixteen passes, then rounding to q16
// and quadrant mapping; depends on grm_pkg
module grm_cordic import grm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ANGLE_W-1:0]       angle,
	output logic                     valid,
	output logic signed [DIR_W-1:0]  dx,
	output logic signed [DIR_W-1:0]  dy
);

	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic [ITER_W-1:0]        iter_q;
	logic [1:0]               quad_q;
	logic                     run_q, round_q, valid_q;
	logic signed [DIR_W-1:0]  dx_q, dy_q;

	logic signed [CORD_W-1:0] xs, ys, x_nx, y_nx, z_nx;
	logic signed [DIR_W-1:0]  c, s;

	// shift with truncation toward zero
	function automatic logic signed [CORD_W-1:0] shr0(input logic signed [CORD_W-1:0] v,
		input logic [ITER_W-1:0] sh);
		logic signed [CORD_W-1:0] bias;
		bias = v[CORD_W-1] ? $signed((CORD_W'(1) << sh) - CORD_W'(1)) : '0;
		return (v + bias) >>> sh;
	endfunction

	// magnitude rounded half up from q30 to q16, sign restored
	function automatic logic signed [DIR_W-1:0] to_q16(input logic signed [CORD_W-1:0] v);
		logic [CORD_W-1:0] m;
		logic [CORD_W-1:0] sum;
		logic [DIR_W-1:0]  q;
		m   = v[CORD_W-1] ? CORD_W'(-v) : CORD_W'(v);
		sum = m + CORD_W'(8192);
		q   = sum[14 +: DIR_W];
		return v[CORD_W-1] ? -$signed(q) : $signed(q);
	endfunction

	always_comb begin
		xs = shr0(x_q, iter_q);
		ys = shr0(y_q, iter_q);
		if (!z_q[CORD_W-1]) begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - arc_of(iter_q);
		end else begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + arc_of(iter_q);
		end
		c = to_q16(x_q);
		s = to_q16(y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			round_q <= 1'b0;
			valid_q <= 1'b0;
		end else if (start) begin
			run_q   <= 1'b1;
			round_q <= 1'b0;
			valid_q <= 1'b0;
		end else if (run_q) begin
			if (iter_q == ITER_LAST) begin
				run_q   <= 1'b0;
				round_q <= 1'b1;
			end
		end else if (round_q) begin
			round_q <= 1'b0;
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORD_X0;
			y_q    <= '0;
			z_q    <= $signed(CORD_W'({angle[ANGLE_W-3:0], 20'b0}));
			iter_q <= '0;
			quad_q <= angle[ANGLE_W-1 -: 2];
		end else if (run_q) begin
			x_q    <= x_nx;
			y_q    <= y_nx;
			z_q    <= z_nx;
			iter_q <= iter_q + ITER_W'(1);
		end
		if (round_q) begin
			case (quad_q)
				2'd0: begin dx_q <= c;  dy_q <= s;  end
				2'd1: begin dx_q <= -s; dy_q <= c;  end
				2'd2: begin dx_q <= -c; dy_q <= -s; end
				default: begin dx_q <= s; dy_q <= -c; end
			endcase
		end
	end

	assign valid = valid_q;
	assign dx    = dx_q;
	assign dy    = dy_q;

endmodule

// ===== rtl/grm_axis.sv =====
// one axis of the ray position kept as cell number plus remainder inside the cell
// short search on load, then one signed add and compare per step; depends on grm_pkg
module grm_axis import grm_pkg::*; #(
	parameter int COUNT = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic signed [POS_W-1:0]         pos,
	input  logic                            step,
	input  logic signed [DIR_W-1:0]         d,
	input  logic [SPAN_W-1:0]               span,
	output axis_stat_t                      stat,
	output logic [$clog2(COUNT+1)-1:0]      cell_no
);

	localparam int K_W = $clog2(COUNT + 1) + 1;
	localparam int C_W = K_W - 1;
	localparam logic signed [K_W-1:0] K_MAX  = K_W'(COUNT);
	localparam logic signed [K_W-1:0] K_ONE  = K_W'(1);
	localparam logic signed [K_W-1:0] K_NEG1 = '1;
	localparam logic signed [K_W-1:0] K_NEG2 = K_NEG1 - K_ONE;

	logic signed [REM_W-1:0] r_q;
	logic signed [K_W-1:0]   k_q;
	logic                    busy_q;

	logic signed [REM_W-1:0] span_e, pos_e, lsum, rs;

	always_comb begin
		span_e = $signed({2'b0, span});
		pos_e  = REM_W'(pos);
		lsum   = pos_e + span_e;
		rs     = r_q + REM_W'(d);
	end

	// busy is control state; remainder and cell number are data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= !pos[POS_W-1];
		end else if (busy_q && !(r_q >= span_e && k_q < K_MAX)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pos[POS_W-1]) begin
				// inside (-span, 0) truncates into cell 0, further down is outside
				r_q <= lsum;
				k_q <= (lsum > 0) ? K_NEG1 : K_NEG2;
			end else begin
				r_q <= pos_e;
				k_q <= '0;
			end
		end else if (busy_q) begin
			if (r_q >= span_e && k_q < K_MAX) begin
				r_q <= r_q - span_e;
				k_q <= k_q + K_ONE;
			end
		end else if (step) begin
			if (rs >= span_e) begin
				r_q <= rs - span_e;
				k_q <= k_q + K_ONE;
			end else if (rs[REM_W-1]) begin
				r_q <= rs + span_e;
				k_q <= k_q - K_ONE;
			end else begin
				r_q <= rs;
			end
		end
	end

	assign stat.busy    = busy_q;
	assign stat.in_grid = (!k_q[K_W-1] && k_q < K_MAX) || (k_q == K_NEG1 && r_q != '0);
	assign cell_no      = k_q[K_W-1] ? '0 : k_q[C_W-1:0];

endmodule

// ===== rtl/grm_checker.sv =====
// port-level checks of the grid ray march block, bound to the top level
// depends on grm_pkg
module grm_checker import grm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_TDATA_W-1:0]  m_tdata
);

	// one ray at a time: busy right after taking an item
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ray taken while previous ray in flight");

	// result held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// a miss carries distance zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[DIST_W:1] == '0)
		else $error("miss with nonzero distance");

	// no result can appear in the cycle right after a ray is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind grid_ray_march_distance grm_checker u_grm_checker (.*);

// ===== verif/grid_ray_march_distance_tb.sv =====
// testbench of the grid ray march block: a directed ray table, then randomized grid setups
// depends on grm_pkg and the grid_ray_march_distance top level, nothing else
module grid_ray_march_distance_tb;
	import grm_pkg::*;

	localparam int GRID_COLS        = 5;
	localparam int GRID_ROWS        = 5;
	localparam int GAP_MAX          = 11;
	localparam int SINK_HOLD_CYCLES = 600;   // long enough to fill the block and stall rays
	localparam int SETTLE_CYCLES    = 1100;  // beyond the slowest ray at render limit 1023
	localparam int RANDOM_PHASES    = 14;

	// unit vector rotator: arctangent of 2^-i in 1/2^32 turn and the pre-scaled start length
	localparam longint TURN_ARCS [16] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861
	};
	localparam longint START_GAIN = 652032875;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} march_result_t;

	typedef struct packed {
		logic [WALL_W-1:0]    walls;
		logic [CELL_SZ_W-1:0] cell_px;
		logic [LIMIT_W-1:0]   limit;
	} grid_setup_t;

	typedef enum logic [2:0] {
		SET_RESET,
		SET_LIMIT_ZERO,
		SET_CELL_ZERO,
		SET_SOLID,
		SET_EMPTY,
		SET_FAR_WALL
	} setup_id_e;

	typedef struct packed {
		setup_id_e                  setup;
		logic signed [ORIGIN_W-1:0] ox;
		logic signed [ORIGIN_W-1:0] oy;
		logic [ANGLE_W-1:0]         angle;
		bit                         fixed;   // expectation typed in below
		march_result_t              want;
	} ray_row_t;

	// fixed grid setups, indexed by setup_id_e
	localparam grid_setup_t FIXED_SETUPS [6] = '{
		'{25'd24700296, 8'd50,  10'd250},    // values after reset
		'{25'd24700296, 8'd50,  10'd0},      // only the start cell counts
		'{25'h1555555,  8'd0,   10'd20},     // zero cell size acts as one pixel
		'{25'h1FFFFFF,  8'd255, 10'd1023},   // every cell a wall, largest cells
		'{25'h0000000,  8'd255, 10'd1023},   // no walls at all
		'{25'h1084210,  8'd255, 10'd1023}    // walls only in the last column, longest walk
	};

	localparam march_result_t MISS  = '{1'b0, 10'd0};
	localparam march_result_t HIT_0 = '{1'b1, 10'd0};

	// directed rays; rows without a typed expectation go through the predictor
	localparam ray_row_t DIRECTED [26] = '{
		'{SET_RESET,      17'sd2560,   17'sd30720,  12'd0,    1'b1, HIT_0}, // starts in a wall
		'{SET_RESET,     -17'sd1,      17'sd30720,  12'd0,    1'b1, HIT_0}, // just below zero
		'{SET_RESET,     -17'sd12800,  17'sd30720,  12'd0,    1'b1, MISS},  // a whole cell below
		'{SET_RESET,     -17'sd65536,  17'sd0,      12'd2048, 1'b1, MISS},
		'{SET_RESET,      17'sd65535,  17'sd0,      12'd0,    1'b1, MISS},
		'{SET_RESET,      17'sd0,     -17'sd65536,  12'd1024, 1'b1, MISS},
		'{SET_RESET,      17'sd0,      17'sd65535,  12'd3072, 1'b1, MISS},
		'{SET_RESET,      17'sd2560,   17'sd2560,   12'd0,    1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd0,    1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd1023, 1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd1024, 1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd2048, 1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd3072, 1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd4095, 1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd512,  1'b0, MISS},
		'{SET_RESET,      17'sd32000,  17'sd32000,  12'd2560, 1'b0, MISS},
		'{SET_LIMIT_ZERO, 17'sd32000,  17'sd32000,  12'd1536, 1'b1, MISS},
		'{SET_LIMIT_ZERO, 17'sd2560,   17'sd30720,  12'd0,    1'b1, HIT_0},
		'{SET_CELL_ZERO,  17'sd0,      17'sd0,      12'd0,    1'b1, HIT_0},
		'{SET_CELL_ZERO,  17'sd256,    17'sd0,      12'd0,    1'b0, MISS},
		'{SET_CELL_ZERO,  17'sd1280,   17'sd0,      12'd0,    1'b1, MISS},
		'{SET_SOLID,      17'sd65535,  17'sd65535,  12'd4095, 1'b1, HIT_0},
		'{SET_SOLID,     -17'sd65536, -17'sd65536,  12'd0,    1'b1, MISS},
		'{SET_EMPTY,      17'sd0,      17'sd0,      12'd512,  1'b1, MISS},
		'{SET_FAR_WALL,   17'sd0,      17'sd0,      12'd0,    1'b0, MISS},
		'{SET_FAR_WALL,   17'sd0,      17'sd65535,  12'd0,    1'b0, MISS}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;   // origin_x[16:0], origin_y[33:17], ray_angle[45:34]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;          // hit[0], distance[10:1]
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [WALL_W-1:0]     cfg_wdata = '0;

	// register copy seen by the predictor
	logic [WALL_W-1:0]     map_bits   = 25'd24700296;
	logic [CELL_SZ_W-1:0]  cell_edge  = 8'd50;
	logic [LIMIT_W-1:0]    step_limit = 10'd250;

	march_result_t due_results [$];   // one per accepted ray, oldest first
	int unsigned   fails         = 0;
	bit            src_calm      = 1'b0;
	bit            sink_calm     = 1'b0;
	bit            sink_hold_req = 1'b0;

	grid_ray_march_distance #(
		.MAP_COLS(GRID_COLS),
		.MAP_ROWS(GRID_ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// q30 to q16, magnitude rounded half up, sign restored
	function automatic longint q30_round(input longint v);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + 8192) / 16384;
		return v < 0 ? -m : m;
	endfunction

	// q16 unit step of a binary angle: rotate inside the quadrant, then swap by quadrant
	function automatic void ray_heading(input logic [ANGLE_W-1:0] angle,
			output longint dx, output longint dy);
		longint x, y, z, xs, ys, c, s;
		x = START_GAIN;
		y = 0;
		z = longint'(angle[ANGLE_W-3:0]) << 20;
		for (int i = 0; i < 16; i++) begin
			// integer division truncates toward zero, as the shifter must
			xs = x / (longint'(1) << i);
			ys = y / (longint'(1) << i);
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= TURN_ARCS[i];
			end else begin
				x += ys;
				y -= xs;
				z += TURN_ARCS[i];
			end
		end
		c = q30_round(x);
		s = q30_round(y);
		case (angle[ANGLE_W-1 -: 2])
			2'd0: begin dx = c;  dy = s;  end
			2'd1: begin dx = -s; dy = c;  end
			2'd2: begin dx = -c; dy = -s; end
			default: begin dx = s; dy = -c; end
		endcase
	endfunction

	// grid cell along one axis, -1 outside; anything in (-span, 0) truncates into cell 0
	function automatic longint axis_cell(input longint pos, input longint span, input int count);
		longint c;
		if (pos >= 0)
			c = pos / span;
		else if (-pos >= span)
			return -1;
		else
			c = 0;
		return c < count ? c : -1;
	endfunction

	// step the ray one pixel at a time until it leaves the grid, meets a wall or runs out
	function automatic march_result_t march_ray(input logic [S_TDATA_W-1:0] word);
		longint px, py, dx, dy, span, cx, cy, idx;
		march_result_t r;
		px = longint'($signed(word[ORIGIN_W-1:0])) * 256;
		py = longint'($signed(word[2*ORIGIN_W-1:ORIGIN_W])) * 256;
		ray_heading(word[2*ORIGIN_W +: ANGLE_W], dx, dy);
		span = longint'(cell_edge == 0 ? 1 : cell_edge) * 65536;
		r = '0;
		for (int n = 0; n <= step_limit; n++) begin
			cx = axis_cell(px, span, GRID_COLS);
			cy = axis_cell(py, span, GRID_ROWS);
			if (cx < 0 || cy < 0)
				return r;
			idx = cy * GRID_COLS + cx;
			if (idx < WALL_W && map_bits[idx]) begin
				r.hit      = 1'b1;
				r.distance = n[DIST_W-1:0];
				return r;
			end
			px += dx;
			py += dy;
		end
		return r;
	endfunction

	function automatic logic [S_TDATA_W-1:0] ray_word(input logic [ORIGIN_W-1:0] ox,
			input logic [ORIGIN_W-1:0] oy, input logic [ANGLE_W-1:0] angle);
		return {{(S_TDATA_W - 2*ORIGIN_W - ANGLE_W){1'b0}}, angle, oy, ox};
	endfunction

	// mostly inside the grid, some just below zero, some anywhere in the field
	function automatic logic [ORIGIN_W-1:0] pick_coord(input int unsigned extent_q8,
			input int unsigned span_q8);
		int v;
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 8)
			v = $urandom_range(0, extent_q8 - 1);
		else if (r == 8)
			v = -int'($urandom_range(1, span_q8));
		else
			v = $urandom;
		return v[ORIGIN_W-1:0];
	endfunction

	function automatic logic [S_TDATA_W-1:0] pick_ray(input logic [CELL_SZ_W-1:0] cell_px);
		int unsigned span_q8, extent_q8;
		span_q8   = (cell_px == 0 ? 1 : cell_px) * 256;
		extent_q8 = span_q8 * GRID_COLS;
		if (extent_q8 > 65536)
			extent_q8 = 65536;
		return ray_word(pick_coord(extent_q8, span_q8), pick_coord(extent_q8, span_q8),
			ANGLE_W'($urandom));
	endfunction

	// three back-to-back register writes, block idle
	task automatic load_setup(input grid_setup_t g);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_WALL_MAP;
		cfg_wdata <= g.walls;
		@(posedge clk);
		cfg_addr  <= REG_CELL_SIZE;
		cfg_wdata <= WALL_W'(g.cell_px);
		@(posedge clk);
		cfg_addr  <= REG_RENDER_LIMIT;
		cfg_wdata <= WALL_W'(g.limit);
		@(posedge clk);
		cfg_we     <= 1'b0;
		map_bits   = g.walls;
		cell_edge  = g.cell_px;
		step_limit = g.limit;
	endtask

	// offer one ray item; valid stays high after acceptance for a back-to-back follower
	task automatic offer_ray(input logic [S_TDATA_W-1:0] word, input bit typed,
			input march_result_t typed_want);
		int unsigned gap;
		gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		due_results.push_back(typed ? typed_want : march_ray(word));
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	// result side: random stall per item, sometimes counted from valid, plus one long hold
	initial begin : result_sink
		int unsigned pause;
		bit lag;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			pause = 0;
			lag   = 1'b0;
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				pause = SINK_HOLD_CYCLES;
			end else if (!sink_calm) begin
				pause = $urandom_range(0, GAP_MAX);
				lag   = $urandom_range(0, 1);
			end
			if (pause > 0) begin
				m_tready <= 1'b0;
				if (lag) begin
					@(posedge clk);
					while (!m_tvalid) @(posedge clk);
				end
				repeat (pause) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// compare each result item with the oldest expectation, field by field
	always @(posedge clk) begin : result_check
		march_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got hit %0b distance %0d",
					$time, m_tdata[0], m_tdata[DIST_W:1]);
				fails++;
			end else begin
				want = due_results.pop_front();
				if (m_tdata[0] !== want.hit) begin
					$display("%0t: hit mismatch, expected %0b, got %0b",
						$time, want.hit, m_tdata[0]);
					fails++;
				end
				if (m_tdata[DIST_W:1] !== want.distance) begin
					$display("%0t: distance mismatch, expected %0d, got %0d",
						$time, want.distance, m_tdata[DIST_W:1]);
					fails++;
				end
			end
		end
	end

	initial begin : stimulus
		setup_id_e   cur;
		grid_setup_t g;
		int          items;
		bit          big;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rays, registers first left at their reset values
		cur = SET_RESET;
		for (int k = 0; k < $size(DIRECTED); k++) begin
			if (DIRECTED[k].setup != cur) begin
				drain_results();
				load_setup(FIXED_SETUPS[DIRECTED[k].setup]);
				cur = DIRECTED[k].setup;
			end
			offer_ray(ray_word(DIRECTED[k].ox, DIRECTED[k].oy, DIRECTED[k].angle),
				DIRECTED[k].fixed, DIRECTED[k].want);
		end
		drain_results();

		// random grid setups; a few large-cell phases are slow, so they get fewer rays
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			big = (ph % 5 == 4);
			case (ph % 3)
				0: g.walls = WALL_W'($urandom);
				1: g.walls = WALL_W'($urandom & $urandom);   // sparse walls
				default: g.walls = WALL_W'($urandom | $urandom);   // dense walls
			endcase
			if (ph == 6)
				g.cell_px = 8'd1;
			else if (big)
				g.cell_px = CELL_SZ_W'($urandom_range(128, 255));
			else
				g.cell_px = CELL_SZ_W'($urandom_range(1, 52));
			if (ph == 0)
				g.limit = LIMIT_W'($urandom_range(0, 200));   // quick rays so the hold fills up
			else if (ph == 2)
				g.limit = '0;
			else if (ph == 3 || big)
				g.limit = 10'd1023;
			else
				g.limit = LIMIT_W'($urandom_range(0, 1023));
			items     = big ? 40 : 100;
			src_calm  = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			load_setup(g);

			// first phase: receiver holds off while rays keep coming back to back
			if (ph == 0) begin
				src_calm      = 1'b1;
				sink_hold_req = 1'b1;
			end
			for (int k = 0; k < items; k++) begin
				// sender pauses now and then until everything is back
				if (k != 0 && k % 50 == 0 && (ph == 1 || $urandom_range(0, 1) == 1))
					drain_results();
				offer_ray(pick_ray(g.cell_px), 1'b0, MISS);
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0 && due_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#12_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== grid_ray_march_distance.f =====
rtl/grm_pkg.sv
rtl/grm_cordic.sv
rtl/grm_axis.sv
rtl/grid_ray_march_distance.sv
rtl/grm_checker.sv
verif/grid_ray_march_distance_tb.sv
